// File: src/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types, widths and codes for the nearest track association block.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam int MAX_PREVIOUS = 64;
    localparam int IDX_W        = (MAX_PREVIOUS > 1) ? $clog2(MAX_PREVIOUS) : 1;
    localparam int CNT_W        = $clog2(MAX_PREVIOUS + 1);

    localparam int POS_W  = 24;
    localparam int VEL_W  = 28;
    localparam int CLS_W  = 8;
    localparam int GATE_W = 40;
    localparam int RATE_W = 16;
    localparam int CFG_W  = 40;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;
    localparam int SUM_W  = SQ_W + 2;

    localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(262144);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(7758);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_MATCH   = 2'd3;

    localparam logic CFG_GATE = 1'b0;
    localparam logic CFG_RATE = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        t_pos             pos;
        logic [CLS_W-1:0] cls;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] z;
    } t_vel;

endpackage

// File: src/nearest_track_association.sv
// ----------------------------------------------------------------------------
// nearest_track_association
// Gated first-match association of current objects against a stored frame.
// ----------------------------------------------------------------------------
// usage:
//   an input word is taken when start is high and busy is low
//   clear, append and the unused code finish at once: o_done in the next
//   cycle, busy stays low, so one of these words can follow every cycle
//   a query rotates the row of 64 cells once past the distance gate, one
//   entry per cycle, then passes three match pipeline registers and two
//   velocity registers before o_done; busy is high from the accepting edge
//   until the result is registered; the cell row length sets the scan length
//   each result is marked by o_done high for exactly one cycle and stays on
//   the outputs until the next one, the receiver cannot hold it off
//   the configuration port writes gate distance (index 0) or rate (index 1);
//   the user must write only while the block is idle; it is unchecked
//   reset empties the store and loads the default gate and rate
// ----------------------------------------------------------------------------
module nearest_track_association (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_operation,
    input  logic signed [nta_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [nta_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [nta_pkg::POS_W-1:0]  i_pos_z,
    input  logic [nta_pkg::CLS_W-1:0]         i_class_tag,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [nta_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic signed [nta_pkg::VEL_W-1:0]  o_vel_x,
    output logic signed [nta_pkg::VEL_W-1:0]  o_vel_y,
    output logic signed [nta_pkg::VEL_W-1:0]  o_vel_z,
    output logic signed [nta_pkg::POS_W-1:0]  o_pred_x,
    output logic signed [nta_pkg::POS_W-1:0]  o_pred_y,
    output logic signed [nta_pkg::POS_W-1:0]  o_pred_z
);
    import nta_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    localparam logic [2:0] WAIT_LAST = 3'd4;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_scan;
    logic [2:0]        r_wait;
    logic [GATE_W-1:0] r_gate;
    logic [RATE_W-1:0] r_rate;
    t_pos              r_cur;
    logic [CLS_W-1:0]  r_cls;

    logic              r_done;
    logic [1:0]        r_status;
    t_vel              r_vel;
    t_pos              r_pred;

    logic      w_accept;
    logic      w_full;
    logic      w_append;
    logic      w_query;
    logic      w_shift;
    logic      w_feed;
    t_entry    w_new;
    t_entry    w_entry [MAX_PREVIOUS];
    t_cell_ctl w_ctl   [MAX_PREVIOUS];
    logic      w_hit;
    t_pos      w_prev;
    t_vel      w_vel;
    t_pos      w_pred;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count >= CNT_W'(MAX_PREVIOUS));
    assign w_append = w_accept && (i_operation == OP_APPEND) && !w_full;
    assign w_query  = w_accept && (i_operation == OP_QUERY);
    assign w_shift  = (r_state == S_SCAN);
    assign w_feed   = w_shift && (r_scan < r_count);

    assign w_new.pos.x = i_pos_x;
    assign w_new.pos.y = i_pos_y;
    assign w_new.pos.z = i_pos_z;
    assign w_new.cls   = i_class_tag;

    // row of cells, rotating toward cell 0 while a query scans
    for (genvar gi = 0; gi < MAX_PREVIOUS; gi++) begin : g_cell
        assign w_ctl[gi].shift = w_shift;
        assign w_ctl[gi].load  = w_append && (r_count[IDX_W-1:0] == IDX_W'(gi));

        nta_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[gi]),
            .i_load_data  (w_new),
            .i_shift_data (w_entry[(gi + 1) % MAX_PREVIOUS]),
            .o_entry      (w_entry[gi])
        );
    end

    nta_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_query),
        .i_feed  (w_feed),
        .i_entry (w_entry[0]),
        .i_cur   (r_cur),
        .i_cls   (r_cls),
        .i_gate  (r_gate),
        .o_hit   (w_hit),
        .o_prev  (w_prev)
    );

    nta_vel u_vel (
        .i_clk  (i_clk),
        .i_hit  (w_hit),
        .i_cur  (r_cur),
        .i_prev (w_prev),
        .i_rate (r_rate),
        .o_vel  (w_vel),
        .o_pred (w_pred)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_scan  <= '0;
            r_wait  <= '0;
            r_gate  <= GATE_RESET;
            r_rate  <= RATE_RESET;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GATE) begin
                    r_gate <= i_cfg_data[GATE_W-1:0];
                end else begin
                    r_rate <= i_cfg_data[RATE_W-1:0];
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_operation == OP_QUERY) begin
                            r_state <= S_SCAN;
                            r_scan  <= '0;
                        end else begin
                            r_done <= 1'b1;
                            if (i_operation == OP_CLEAR) begin
                                r_count <= '0;
                            end else if (w_append) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + CNT_W'(1);
                    if (r_scan == CNT_W'(MAX_PREVIOUS - 1)) begin
                        r_state <= S_WAIT;
                        r_wait  <= '0;
                    end
                end
                S_WAIT: begin
                    r_wait <= r_wait + 3'd1;
                    if (r_wait == WAIT_LAST) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur <= w_new.pos;
            r_cls <= i_class_tag;
        end
        if (w_accept && (i_operation != OP_QUERY)) begin
            r_status <= (i_operation == OP_APPEND && w_full) ? ST_FULL : ST_OK;
            r_vel    <= '0;
            r_pred   <= '0;
        end else if ((r_state == S_WAIT) && (r_wait == WAIT_LAST)) begin
            r_status <= w_hit ? ST_MATCH : ST_NOMATCH;
            r_vel    <= w_vel;
            r_pred   <= w_pred;
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_vel_x  = r_vel.x;
    assign o_vel_y  = r_vel.y;
    assign o_vel_z  = r_vel.z;
    assign o_pred_x = r_pred.x;
    assign o_pred_y = r_pred.y;
    assign o_pred_z = r_pred.z;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PREVIOUS))
        else $error("store count above capacity");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (r_count == CNT_W'(MAX_PREVIOUS)))
        else $error("dropped append while store not full");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NOMATCH) |->
        (o_vel_x == '0 && o_vel_y == '0 && o_vel_z == '0))
        else $error("nonzero velocity without match");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_query) |=> busy)
        else $error("query accepted without going busy");

    a_query_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_MATCH || o_status == ST_NOMATCH)) |->
        ($past(r_state) == S_WAIT))
        else $error("query result outside scan sequence");
`endif

endmodule

// File: src/nta_cell.sv
// ----------------------------------------------------------------------------
// nta_cell
// One stored previous object; loads on append, takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module nta_cell (
    input  logic               i_clk,
    input  nta_pkg::t_cell_ctl i_ctl,
    input  nta_pkg::t_entry    i_load_data,
    input  nta_pkg::t_entry    i_shift_data,
    output nta_pkg::t_entry    o_entry
);
    import nta_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_load_data;
        end else if (i_ctl.shift) begin
            n_entry = i_shift_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: src/nta_match.sv
// ----------------------------------------------------------------------------
// nta_match
// Distance gate at the head of the cell row; keeps the first matching entry.
// ----------------------------------------------------------------------------
module nta_match (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic                          i_feed,
    input  nta_pkg::t_entry               i_entry,
    input  nta_pkg::t_pos                 i_cur,
    input  logic [nta_pkg::CLS_W-1:0]     i_cls,
    input  logic [nta_pkg::GATE_W-1:0]    i_gate,
    output logic                          o_hit,
    output nta_pkg::t_pos                 o_prev
);
    import nta_pkg::*;

    // stage a: class test and differences
    logic                     r_a_vld;
    logic signed [DIFF_W-1:0] r_a_dx, r_a_dy, r_a_dz;
    t_pos                     r_a_prev;

    // stage b: squares
    logic                     r_b_vld;
    logic [SQ_W-1:0]          r_b_sqx, r_b_sqy, r_b_sqz;
    t_pos                     r_b_prev;

    logic signed [2*DIFF_W-1:0] w_sqx, w_sqy, w_sqz;
    logic [SUM_W-1:0]           w_sum;
    logic                       w_take;

    logic r_hit;
    t_pos r_prev;

    assign w_sqx = r_a_dx * r_a_dx;
    assign w_sqy = r_a_dy * r_a_dy;
    assign w_sqz = r_a_dz * r_a_dz;

    assign w_sum  = SUM_W'(r_b_sqx) + SUM_W'(r_b_sqy) + SUM_W'(r_b_sqz);
    assign w_take = r_b_vld && !r_hit && (w_sum < SUM_W'(i_gate));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_a_vld <= i_feed && (i_entry.cls == i_cls);
            r_b_vld <= r_a_vld;
            if (i_clr) begin
                r_hit <= 1'b0;
            end else if (w_take) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dx   <= DIFF_W'(i_cur.x) - DIFF_W'(i_entry.pos.x);
        r_a_dy   <= DIFF_W'(i_cur.y) - DIFF_W'(i_entry.pos.y);
        r_a_dz   <= DIFF_W'(i_cur.z) - DIFF_W'(i_entry.pos.z);
        r_a_prev <= i_entry.pos;
        r_b_sqx  <= w_sqx[SQ_W-1:0];
        r_b_sqy  <= w_sqy[SQ_W-1:0];
        r_b_sqz  <= w_sqz[SQ_W-1:0];
        r_b_prev <= r_a_prev;
        if (w_take) begin
            r_prev <= r_b_prev;
        end
    end

    assign o_hit  = r_hit;
    assign o_prev = r_prev;

endmodule

// File: src/nta_vel.sv
// ----------------------------------------------------------------------------
// nta_vel
// Velocity and one-frame prediction from the current and matched positions.
// ----------------------------------------------------------------------------
module nta_vel (
    input  logic                       i_clk,
    input  logic                       i_hit,
    input  nta_pkg::t_pos              i_cur,
    input  nta_pkg::t_pos              i_prev,
    input  logic [nta_pkg::RATE_W-1:0] i_rate,
    output nta_pkg::t_vel              o_vel,
    output nta_pkg::t_pos              o_pred
);
    import nta_pkg::*;

    localparam int PROD_W = DIFF_W + RATE_W + 1;
    localparam int PRED_W = POS_W + 2;

    localparam logic signed [PROD_W-1:0] VEL_HI = PROD_W'((64'sd1 <<< (VEL_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] VEL_LO = PROD_W'(-(64'sd1 <<< (VEL_W - 1)));
    localparam logic signed [PRED_W-1:0] POS_HI = PRED_W'((64'sd1 <<< (POS_W - 1)) - 1);
    localparam logic signed [PRED_W-1:0] POS_LO = PRED_W'(-(64'sd1 <<< (POS_W - 1)));
    localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(128);

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = (p + HALF) >>> 8;
        if (q > VEL_HI) begin
            q = VEL_HI;
        end else if (q < VEL_LO) begin
            q = VEL_LO;
        end
        return q[VEL_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PRED_W-1:0] v);
        logic signed [PRED_W-1:0] q;
        q = v;
        if (q > POS_HI) begin
            q = POS_HI;
        end else if (q < POS_LO) begin
            q = POS_LO;
        end
        return q[POS_W-1:0];
    endfunction

    logic signed [POS_W-1:0]  w_cur  [3];
    logic signed [POS_W-1:0]  w_prev [3];
    logic signed [DIFF_W-1:0] r_d    [3];
    logic signed [PRED_W-1:0] r_pred [3];
    logic signed [PRED_W-1:0] r_pred2[3];
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [RATE_W:0]   w_rate;

    assign w_cur[0]  = i_cur.x;
    assign w_cur[1]  = i_cur.y;
    assign w_cur[2]  = i_cur.z;
    assign w_prev[0] = i_hit ? i_prev.x : i_cur.x;
    assign w_prev[1] = i_hit ? i_prev.y : i_cur.y;
    assign w_prev[2] = i_hit ? i_prev.z : i_cur.z;
    assign w_rate    = signed'({1'b0, i_rate});

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_d[a]     <= DIFF_W'(w_cur[a]) - DIFF_W'(w_prev[a]);
            r_pred[a]  <= (PRED_W'(w_cur[a]) <<< 1) - PRED_W'(w_prev[a]);
            r_prod[a]  <= r_d[a] * w_rate;
            r_pred2[a] <= r_pred[a];
        end
    end

    assign o_vel.x  = sat_vel(r_prod[0]);
    assign o_vel.y  = sat_vel(r_prod[1]);
    assign o_vel.z  = sat_vel(r_prod[2]);
    assign o_pred.x = sat_pos(r_pred2[0]);
    assign o_pred.y = sat_pos(r_pred2[1]);
    assign o_pred.z = sat_pos(r_pred2[2]);

endmodule
